/* design/ffsa_pkg.sv */
// Package for the first-free slot allocator.
// Holds the table sizes, operation and status codes shared by the design.
// No dependencies.
package ffsa_pkg;

  // Table geometry.
  localparam int MAX_SLOTS  = 256;
  localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
  localparam int COUNT_BITS = SLOT_BITS + 1;
  localparam int OWNER_BITS = 16;

  // The occupancy search is split into groups, one half of the index each.
  localparam int GRP_BITS     = SLOT_BITS / 2;
  localparam int GRP_SIZE     = 1 << GRP_BITS;
  localparam int NUM_GRP_BITS = SLOT_BITS - GRP_BITS;
  localparam int NUM_GRP      = MAX_SLOTS >> GRP_BITS;

  // Operation codes.
  localparam logic [1:0] OP_RESERVE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_FULL         = 3'd1;
  localparam logic [2:0] ST_INVALID      = 3'd2;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
  localparam logic [2:0] ST_OWNER_ZERO   = 3'd4;

  // Slot count after reset, also the upper bound to which a written count is clamped.
  localparam logic [COUNT_BITS-1:0] SLOT_COUNT_RESET = COUNT_BITS'(MAX_SLOTS);

endpackage

/* design/first_free_slot_allocator_core.sv */
// First-free slot allocator: owner memory, occupancy bitmap and counters.
// Depends on ffsa_pkg for sizes and codes.
//
// Usage:
//   The request channel (in_valid, in_stall) carries one beat per request:
//   operation, owner_id and slot_number. The result channel (out_valid,
//   out_stall) carries one beat per request: status, granted_slot,
//   slot_owner, free_slots and used_slots.
//   The configuration channel (cfg_valid, cfg_ready) writes slot_count;
//   a write clamps the value to 1..256, frees every slot and resets the
//   counters. It is taken only while no request is in progress, and while
//   a write is offered the request channel is stalled.
// Sequence:
//   When a request is accepted, the owner memory is read and the first
//   level of the free-slot search is registered; in the EXEC state the
//   result is formed, written back and loaded into the output register.
//   A new request is taken only after the previous one has completed.
// Reset and stall:
//   Reset (rst, synchronous) frees every slot with a slot count of 256.
//   While out_stall holds a result, the next request waits in the EXEC
//   state and in_stall stays high.
module first_free_slot_allocator_core
  import ffsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [OWNER_BITS-1:0] owner_id,
  input  logic [COUNT_BITS-1:0] slot_number,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [COUNT_BITS-1:0] granted_slot,
  output logic [OWNER_BITS-1:0] slot_owner,
  output logic [COUNT_BITS-1:0] free_slots,
  output logic [COUNT_BITS-1:0] used_slots,
  // Configuration channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_BITS-1:0] slot_count
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                    state;
  logic                    in_take;
  logic                    exec_done;

  // Request held for the EXEC state.
  logic [1:0]              op_q;
  logic [OWNER_BITS-1:0]   owner_q;
  logic [COUNT_BITS-1:0]   slot_q;
  logic [SLOT_BITS-1:0]    slot_idx_q;

  // Owner memory and occupancy bitmap.
  logic [OWNER_BITS-1:0]   owner_mem [MAX_SLOTS];
  logic [OWNER_BITS-1:0]   rd_data;
  logic                    mem_we;
  logic [MAX_SLOTS-1:0]    occ;

  // Counters and slot count register.
  logic [COUNT_BITS-1:0]   count_q;
  logic [COUNT_BITS-1:0]   free_total;
  logic [COUNT_BITS-1:0]   used_total;
  logic [COUNT_BITS-1:0]   cfg_count;

  // Free-slot search, first level registered.
  logic [NUM_GRP-1:0]      grp_any;
  logic [GRP_BITS-1:0]     grp_idx [NUM_GRP];
  logic [NUM_GRP-1:0]      grp_any_q;
  logic [GRP_BITS-1:0]     grp_idx_q [NUM_GRP];
  logic [NUM_GRP_BITS-1:0] sel_grp;
  logic [SLOT_BITS-1:0]    first_free;

  // Result formed in the EXEC state.
  logic                    slot_ok;
  logic                    slot_occ;
  logic [2:0]              res_status;
  logic [COUNT_BITS-1:0]   res_granted;
  logic [OWNER_BITS-1:0]   res_owner;
  logic                    do_grant;
  logic                    do_free;

  // Handshakes. A pending configuration write goes ahead of a request.
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = (state == S_IDLE);
  assign exec_done = (state == S_EXEC) && (!out_valid || !out_stall);

  // Clamp a written slot count to the legal range.
  always_comb begin
    if (slot_count == '0) begin
      cfg_count = COUNT_BITS'(1);
    end else if (slot_count > SLOT_COUNT_RESET) begin
      cfg_count = SLOT_COUNT_RESET;
    end else begin
      cfg_count = slot_count;
    end
  end

  // First level of the search: the lowest free slot inside each group.
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_any[g] = ~&occ[g*GRP_SIZE +: GRP_SIZE];
      grp_idx[g] = '0;
      for (int j = GRP_SIZE - 1; j >= 0; j--) begin
        if (!occ[g*GRP_SIZE + j]) begin
          grp_idx[g] = GRP_BITS'(j);
        end
      end
    end
  end

  // Second level: the lowest group that has a free slot.
  always_comb begin
    sel_grp = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        sel_grp = NUM_GRP_BITS'(g);
      end
    end
    first_free = {sel_grp, grp_idx_q[sel_grp]};
  end

  // Decide the outcome of the held request.
  always_comb begin
    slot_ok     = (slot_q != '0) && (slot_q <= count_q);
    slot_occ    = occ[slot_idx_q];
    res_status  = ST_OK;
    res_granted = '0;
    res_owner   = '0;
    do_grant    = 1'b0;
    do_free     = 1'b0;
    case (op_q)
      OP_RESERVE: begin
        if (owner_q == '0) begin
          res_status = ST_OWNER_ZERO;
        end else if (free_total == '0) begin
          res_status = ST_FULL;
        end else begin
          do_grant    = 1'b1;
          res_granted = COUNT_BITS'(first_free) + COUNT_BITS'(1);
        end
      end
      OP_RELEASE: begin
        if (!slot_ok) begin
          res_status = ST_INVALID;
        end else if (!slot_occ) begin
          res_status = ST_ALREADY_FREE;
        end else begin
          do_free   = 1'b1;
          res_owner = rd_data;
        end
      end
      OP_QUERY: begin
        if (!slot_ok) begin
          res_status = ST_INVALID;
        end else if (slot_occ) begin
          res_owner = rd_data;
        end
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  assign mem_we = exec_done && do_grant;

  // Owner memory: read at acceptance, written when a slot is granted.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      owner_mem[first_free] <= owner_q;
    end
    if (in_take) begin
      rd_data <= owner_mem[SLOT_BITS'(slot_number[SLOT_BITS-1:0] - 1'b1)];
    end
  end

  // Request capture and first search level.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q       <= operation;
      owner_q    <= owner_id;
      slot_q     <= slot_number;
      slot_idx_q <= SLOT_BITS'(slot_number[SLOT_BITS-1:0] - 1'b1);
      grp_any_q  <= grp_any;
      grp_idx_q  <= grp_idx;
    end
  end

  // Sequencer, bitmap and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      occ        <= '0;
      count_q    <= SLOT_COUNT_RESET;
      free_total <= SLOT_COUNT_RESET;
      used_total <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        occ        <= '0;
        count_q    <= cfg_count;
        free_total <= cfg_count;
        used_total <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_done) begin
            state <= S_IDLE;
            if (do_grant) begin
              occ[first_free] <= 1'b1;
              free_total      <= free_total - 1'b1;
              used_total      <= used_total + 1'b1;
            end else if (do_free) begin
              occ[slot_idx_q] <= 1'b0;
              free_total      <= free_total + 1'b1;
              used_total      <= used_total - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when a request completes, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      status       <= res_status;
      granted_slot <= res_granted;
      slot_owner   <= res_owner;
      free_slots   <= do_grant ? free_total - 1'b1 :
                      do_free  ? free_total + 1'b1 : free_total;
      used_slots   <= do_grant ? used_total + 1'b1 :
                      do_free  ? used_total - 1'b1 : used_total;
    end
  end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the first-free slot allocator core.
// Predicts every result beat from its own copy of the slot owners and counters.
// Depends on ffsa_pkg and first_free_slot_allocator_core.
module tb_top
  import ffsa_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Operation code that the block must reject as undefined.
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0]            status;
    logic [COUNT_BITS-1:0] granted;
    logic [OWNER_BITS-1:0] owner;
    logic [COUNT_BITS-1:0] free_n;
    logic [COUNT_BITS-1:0] used_n;
  } alloc_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            operation = '0;
  logic [OWNER_BITS-1:0] owner_id = '0;
  logic [COUNT_BITS-1:0] slot_number = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            status;
  logic [COUNT_BITS-1:0] granted_slot;
  logic [OWNER_BITS-1:0] slot_owner;
  logic [COUNT_BITS-1:0] free_slots;
  logic [COUNT_BITS-1:0] used_slots;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [COUNT_BITS-1:0] slot_count = '0;

  // Predicted state of the allocator.
  logic [OWNER_BITS-1:0] owner_tbl [MAX_SLOTS];
  int slot_limit;
  int free_total;
  int used_total;

  alloc_result_t pending_outcomes [$];
  int items_taken = 0;
  int results_taken = 0;
  int cfg_taken = 0;
  int full_rejects = 0;
  int error_count = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  first_free_slot_allocator_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .owner_id     (owner_id),
    .slot_number  (slot_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_slot (granted_slot),
    .slot_owner   (slot_owner),
    .free_slots   (free_slots),
    .used_slots   (used_slots),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .slot_count   (slot_count)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp the slot count to its legal range and free every slot.
  function automatic void clear_slots(logic [COUNT_BITS-1:0] requested);
    int n;
    n = requested;
    if (n < 1) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    slot_limit = n;
    foreach (owner_tbl[i]) owner_tbl[i] = '0;
    free_total = n;
    used_total = 0;
  endfunction

  // Work out the result beat of one request and update the predicted state.
  function automatic alloc_result_t allocate_outcome(logic [1:0] op,
                                                     logic [OWNER_BITS-1:0] owner,
                                                     logic [COUNT_BITS-1:0] slot);
    alloc_result_t r;
    bit in_range;
    bit found;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    in_range = (slot >= 1) && (slot <= slot_limit);
    case (op)
      OP_RESERVE: begin
        if (owner == '0) begin
          r.status = ST_OWNER_ZERO;
        end else if (free_total == 0) begin
          r.status = ST_FULL;
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < slot_limit; i++) begin
            if (!found && owner_tbl[i] == '0) begin
              owner_tbl[i] = owner;
              free_total--;
              used_total++;
              r.granted = COUNT_BITS'(i + 1);
              r.status = ST_OK;
              found = 1'b1;
            end
          end
        end
      end
      OP_RELEASE: begin
        if (!in_range) begin
          r.status = ST_INVALID;
        end else if (owner_tbl[slot-1] == '0) begin
          r.status = ST_ALREADY_FREE;
        end else begin
          r.owner = owner_tbl[slot-1];
          owner_tbl[slot-1] = '0;
          free_total++;
          used_total--;
        end
      end
      OP_QUERY: begin
        if (!in_range) r.status = ST_INVALID;
        else r.owner = owner_tbl[slot-1];
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    r.free_n = COUNT_BITS'(free_total);
    r.used_n = COUNT_BITS'(used_total);
    return r;
  endfunction

  // Observe every beat at the rising edge: check results, predict requests.
  always @(posedge clk) begin : observe
    alloc_result_t got;
    alloc_result_t want;
    bit progress;
    progress = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        results_taken++;
        got = '{status, granted_slot, slot_owner, free_slots, used_slots};
        if (pending_outcomes.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("Result beat with nothing expected: status %0d slot %0d owner %0h",
                     got.status, got.granted, got.owner);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.status !== want.status || got.granted !== want.granted ||
              got.owner !== want.owner || got.free_n !== want.free_n ||
              got.used_n !== want.used_n) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("Result %0d differs: expected status %0d slot %0d owner %0h free %0d used %0d",
                       results_taken, want.status, want.granted, want.owner,
                       want.free_n, want.used_n);
              $display("  got status %0d slot %0d owner %0h free %0d used %0d",
                       got.status, got.granted, got.owner, got.free_n, got.used_n);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        progress = 1'b1;
        want = allocate_outcome(operation, owner_id, slot_number);
        if (want.status == ST_FULL) full_rejects++;
        pending_outcomes.push_back(want);
        items_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        clear_slots(slot_count);
        cfg_taken++;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
    end
  end

  // Stop a hung run.
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("first_free_slot_allocator_core: mismatch");
    $finish;
  end

  // Random gap length: mostly none or short, occasionally long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result-side back-pressure, in runs of random length.
  initial begin : result_stall
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!no_idle && $urandom_range(0, 99) < 30) begin
        out_stall = 1'b1;
        hold = pick_gap();
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Present one request beat and hold it until it is taken.
  task automatic send_request(input logic [1:0] op, input logic [OWNER_BITS-1:0] owner,
                              input logic [COUNT_BITS-1:0] slot);
    int gap;
    int seen;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    owner_id = owner;
    slot_number = slot;
    in_valid = 1'b1;
    seen = items_taken;
    do @(negedge clk); while (items_taken == seen);
  endtask

  // Write the slot count once every outstanding result has come back.
  task automatic write_slot_count(input logic [COUNT_BITS-1:0] value);
    int seen;
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    slot_count = value;
    cfg_valid = 1'b1;
    seen = cfg_taken;
    do @(negedge clk); while (cfg_taken == seen);
    cfg_valid = 1'b0;
  endtask

  // Slot number for a release or query, biased towards occupied slots.
  function automatic logic [COUNT_BITS-1:0] pick_slot();
    int r;
    int hi;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      if ($urandom_range(0, 3) == 0) return '0;
      return COUNT_BITS'($urandom_range(slot_limit + 1, (1 << COUNT_BITS) - 1));
    end
    if (r < 75) begin
      hi = used_total + 3;
      if (hi > slot_limit) hi = slot_limit;
      return COUNT_BITS'($urandom_range(1, hi));
    end
    return COUNT_BITS'($urandom_range(1, slot_limit));
  endfunction

  // Field extremes, every operation and each error path.
  task automatic test_directed();
    send_request(OP_QUERY, 16'h0000, 9'd0);
    send_request(OP_QUERY, 16'hFFFF, 9'd256);
    send_request(OP_QUERY, 16'h0000, 9'd257);
    send_request(OP_QUERY, 16'h0000, 9'd511);
    send_request(OP_RELEASE, 16'hFFFF, 9'd1);
    send_request(OP_RESERVE, 16'h0000, 9'd0);
    send_request(OP_RESERVE, 16'hFFFF, 9'd511);
    send_request(OP_RESERVE, 16'h0001, 9'd0);
    send_request(OP_QUERY, 16'h0000, 9'd1);
    send_request(OP_RELEASE, 16'h0000, 9'd1);
    send_request(OP_RESERVE, 16'h8000, 9'd0);
    send_request(OP_UNDEFINED, 16'hFFFF, 9'd1);
    send_request(OP_UNDEFINED, 16'h0000, 9'd511);
    send_request(OP_RELEASE, 16'h1234, 9'd0);
    send_request(OP_RELEASE, 16'h1234, 9'd257);
    // A single-slot table: fills at once, and a zero owner beats the full check.
    write_slot_count(9'd0);
    send_request(OP_RESERVE, 16'hA5A5, 9'd0);
    send_request(OP_RESERVE, 16'h5A5A, 9'd0);
    send_request(OP_RESERVE, 16'h0000, 9'd0);
    send_request(OP_QUERY, 16'h0000, 9'd1);
    send_request(OP_QUERY, 16'h0000, 9'd2);
    send_request(OP_RELEASE, 16'h0000, 9'd1);
    send_request(OP_RELEASE, 16'h0000, 9'd1);
  endtask

  // Largest table: an oversized count write, a complete fill and refills.
  task automatic test_full_table();
    int slot;
    write_slot_count(9'd511);
    repeat (MAX_SLOTS) send_request(OP_RESERVE, 16'($urandom_range(1, 65535)), '0);
    send_request(OP_RESERVE, 16'hFFFF, 9'h1FF);
    send_request(OP_RESERVE, 16'h0000, 9'h1FF);
    repeat (5) begin
      slot = $urandom_range(1, MAX_SLOTS);
      send_request(OP_RELEASE, '0, COUNT_BITS'(slot));
      send_request(OP_RESERVE, 16'($urandom_range(1, 65535)), '0);
      send_request(OP_QUERY, '0, COUNT_BITS'(slot));
    end
    write_slot_count(9'd256);
    send_request(OP_QUERY, '0, 9'd256);
  endtask

  // Mixed random traffic over a range of slot counts.
  task automatic test_random_traffic();
    int reserve_bias;
    int r;
    int count;
    logic [1:0] op;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 6)
        0: count = $urandom_range(1, 8);
        1: count = $urandom_range(9, 40);
        2: count = 256;
        3: count = $urandom_range(2, 16);
        4: begin
          r = $urandom_range(0, 3);
          count = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 511 : $urandom_range(257, 510);
        end
        default: count = $urandom_range(41, 255);
      endcase
      write_slot_count(COUNT_BITS'(count));
      no_idle = (phase % 4 == 3);
      reserve_bias = $urandom_range(35, 70);
      repeat (125) begin
        r = $urandom_range(0, 99);
        if (r < reserve_bias) begin
          if ($urandom_range(0, 29) == 0)
            send_request(OP_RESERVE, '0, COUNT_BITS'($urandom()));
          else
            send_request(OP_RESERVE, 16'($urandom_range(1, 65535)), COUNT_BITS'($urandom()));
        end else if (r < 97) begin
          op = $urandom_range(0, 1) ? OP_RELEASE : OP_QUERY;
          send_request(op, OWNER_BITS'($urandom()), pick_slot());
        end else begin
          send_request(OP_UNDEFINED, OWNER_BITS'($urandom()), COUNT_BITS'($urandom()));
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // Test sequence.
  initial begin
    clear_slots(SLOT_COUNT_RESET);
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_full_table();
    test_random_traffic();
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Checked %0d result beats from %0d requests across %0d slot-count writes.",
             results_taken, items_taken, cfg_taken);
    $display("%0d reserves met a full table; %0d results differed.",
             full_rejects, error_count);
    if (error_count == 0 && pending_outcomes.size() == 0)
      $display("first_free_slot_allocator_core: match");
    else
      $display("first_free_slot_allocator_core: mismatch");
    $finish;
  end

endmodule

/* sim.f */
design/ffsa_pkg.sv
design/first_free_slot_allocator_core.sv
sim/tb_top.sv
